### sv/swrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding window range tracker.
// No dependencies; used by the cell, the top level and the checker.
package swrt_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;

  // xor with this turns a two's complement word into an unsigned order key
  localparam logic [DATA_W-1:0] SIGN_FLIP = 32'h8000_0000;

  // running extremes carried down the cell chain
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

endpackage

### sv/sliding_window_range_tracker_unit.sv
`timescale 1ns / 1ps
// Sliding window range tracker: top level with the cell chain and control.
// Depends on swrt_pkg and swrt_cell.
//
// Each accepted sample shifts into a chain of MAX_WINDOW cells, newest at
// cell 0. A max/min token then walks the chain one cell per clock, folding
// in the first window_length cells. When the token leaves the last cell the
// result is registered, then loaded into the output register. in_ready rises
// in the cycle after the result is loaded, so a new item is taken only once
// the last one is through. in_ready is high while no item is in flight;
// a finished result waits in the output register until taken. Window
// length 0 acts as 1, and lengths above MAX_WINDOW act as MAX_WINDOW.
// last_sample closes the sequence: count and best range restart at zero.
module sliding_window_range_tracker_unit #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [swrt_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [swrt_pkg::DATA_W-1:0] in_sample,
  input  logic                               in_last_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_window_full,
  output logic [swrt_pkg::DATA_W-1:0]        out_window_range,
  output logic [swrt_pkg::DATA_W-1:0]        out_best_range,
  output logic                               out_sequence_end
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int DW = swrt_pkg::DATA_W;

  swrt_pkg::state_t state_r, state_nxt;

  logic [swrt_pkg::CFG_W-1:0] cfg_len_r;
  logic [CW-1:0]              len_eff;
  logic [31:0]                len32;
  logic [CW-1:0]              seen_r, seen_inc;
  logic [DW-1:0]              best_r;
  logic                       start_r;
  logic                       full_r, last_r;
  logic [DW-1:0]              pend_range_r, pend_best_r;
  logic                       out_valid_r;
  logic                       out_full_r, out_end_r;
  logic [DW-1:0]              out_range_r, out_best_r;

  logic                       accept;
  logic                       load_out;
  logic                       tail_done;
  logic [DW-1:0]              tail_range, range_g, best_upd;

  logic [DW-1:0]              key_chain [0:MAX_WINDOW];
  swrt_pkg::tok_t             tok_chain [0:MAX_WINDOW];

  // effective window length
  always_comb begin
    len32 = 32'(cfg_len_r);
    if (len32 == 32'd0) begin
      len_eff = CW'(1);
    end else if (len32 > 32'(MAX_WINDOW)) begin
      len_eff = CW'(MAX_WINDOW);
    end else begin
      len_eff = CW'(len32);
    end
  end

  assign seen_inc = (seen_r == CW'(MAX_WINDOW)) ? seen_r : seen_r + CW'(1);

  // cell chain
  assign key_chain[0]     = in_sample ^ swrt_pkg::SIGN_FLIP;
  assign tok_chain[0].vld = start_r;
  assign tok_chain[0].hi  = '0;
  assign tok_chain[0].lo  = '1;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    swrt_cell #(
      .IDX (k),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .key_in   (key_chain[k]),
      .key_out  (key_chain[k+1]),
      .len      (len_eff),
      .tok_in   (tok_chain[k]),
      .tok_out  (tok_chain[k+1])
    );
  end

  assign tail_done  = tok_chain[MAX_WINDOW].vld;
  assign tail_range = tok_chain[MAX_WINDOW].hi - tok_chain[MAX_WINDOW].lo;
  assign range_g    = full_r ? tail_range : '0;
  assign best_upd   = (range_g > best_r) ? range_g : best_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swrt_pkg::ST_IDLE: if (in_valid) state_nxt = swrt_pkg::ST_SCAN;
      swrt_pkg::ST_SCAN: if (tail_done) state_nxt = swrt_pkg::ST_WAIT;
      swrt_pkg::ST_WAIT: if (!out_valid_r || out_ready) state_nxt = swrt_pkg::ST_IDLE;
      default:           state_nxt = swrt_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      swrt_pkg::ST_IDLE: in_ready = 1'b1;
      swrt_pkg::ST_SCAN: ;
      swrt_pkg::ST_WAIT: load_out = !out_valid_r || out_ready;
      default:           ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swrt_pkg::ST_IDLE;
      cfg_len_r   <= swrt_pkg::CFG_W'(1);
      seen_r      <= '0;
      best_r      <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
      if (cfg_wr_en) cfg_len_r <= cfg_wr_data;
      if (accept) seen_r <= in_last_sample ? '0 : seen_inc;
      if (state_r == swrt_pkg::ST_SCAN && tail_done) begin
        best_r <= last_r ? '0 : best_upd;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      full_r <= (seen_inc >= len_eff);
      last_r <= in_last_sample;
    end
    if (state_r == swrt_pkg::ST_SCAN && tail_done) begin
      pend_range_r <= range_g;
      pend_best_r  <= best_upd;
    end
    if (load_out) begin
      out_full_r  <= full_r;
      out_range_r <= pend_range_r;
      out_best_r  <= pend_best_r;
      out_end_r   <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_full  = out_full_r;
  assign out_window_range = out_range_r;
  assign out_best_range   = out_best_r;
  assign out_sequence_end = out_end_r;

endmodule

### sv/swrt_cell.sv
`timescale 1ns / 1ps
// One cell of the window chain: holds one sample key and folds it into
// the passing max/min token if inside the window. Depends on swrt_pkg.
module swrt_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift_en,
  input  logic [swrt_pkg::DATA_W-1:0]  key_in,
  output logic [swrt_pkg::DATA_W-1:0]  key_out,
  input  logic [CW-1:0]                len,
  input  swrt_pkg::tok_t               tok_in,
  output swrt_pkg::tok_t               tok_out
);

  logic [swrt_pkg::DATA_W-1:0] key_r;
  swrt_pkg::tok_t              tok_r;
  swrt_pkg::tok_t              tok_nxt;
  logic                        in_window;

  assign in_window = (CW'(IDX) < len);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && in_window) begin
      if (key_r > tok_in.hi) tok_nxt.hi = key_r;
      if (key_r < tok_in.lo) tok_nxt.lo = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) key_r <= key_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.hi <= tok_nxt.hi;
    tok_r.lo <= tok_nxt.lo;
  end

  assign key_out = key_r;
  assign tok_out = tok_r;

endmodule

### sv/swrt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sliding window range tracker, bound to the top.
// Depends on swrt_pkg and sliding_window_range_tracker_unit.
module swrt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_window_full,
  input logic [swrt_pkg::DATA_W-1:0] out_window_range,
  input logic [swrt_pkg::DATA_W-1:0] out_best_range,
  input logic                        out_sequence_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_range)
      && $stable(out_best_range) && $stable(out_window_full)
      && $stable(out_sequence_end))
    else $error("result changed while stalled");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_full |-> out_window_range == '0)
    else $error("range reported without a full window");

  a_best_ge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_range >= out_window_range)
    else $error("best range below window range");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

bind sliding_window_range_tracker_unit swrt_checker u_swrt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_window_full  (out_window_full),
  .out_window_range (out_window_range),
  .out_best_range   (out_best_range),
  .out_sequence_end (out_sequence_end)
);
